>>> src/ks01_pkg.sv
// shared types and constants of the 0/1 knapsack solver
package ks01_pkg;

    // field widths of the item channels
    localparam int VALUE_W  = 16;
    localparam int COST_W   = 8;
    localparam int BUDGET_W = 8;
    localparam int TOTAL_W  = 21;
    localparam int INDEX_W  = 5;

    typedef logic [TOTAL_W-1:0] t_total;
    typedef logic [INDEX_W-1:0] t_index;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_SOLVE = 1'b1
    } t_op;

    typedef enum logic {
        KIND_TOTAL = 1'b0,
        KIND_INDEX = 1'b1
    } t_kind;

    typedef struct packed {
        t_op                 operation;
        logic [VALUE_W-1:0]  item_value;
        logic [COST_W-1:0]   item_cost;
        logic [BUDGET_W-1:0] budget;
    } t_in_item;

    typedef struct packed {
        t_kind  result_kind;
        t_total best_total;
        t_index chosen_index;
        logic   items_dropped;
        logic   last_result;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_LOAD,
        S_ROW,
        S_TOTREAD,
        S_TOTAL,
        S_TWAIT,
        S_TCHK,
        S_FLUSH
    } t_state;

    // sequencer to row unit
    typedef struct packed {
        logic clear;
        logic issue;
    } t_row_ctl;

    // row unit to sequencer
    typedef struct packed {
        logic done;
        logic take;
    } t_row_sts;

endpackage

>>> src/ks01_stream_if.sv
// valid/ready stream interface carrying one item per handshake
interface ks01_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/ks01_row_unit.sv
// best-value row memory with the shared add and compare unit
module ks01_row_unit #(
    parameter int COL_W = 8,
    parameter int VAL_W = 22
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ks01_pkg::t_row_ctl    i_ctl,
    input  logic [COL_W-1:0]      i_col,
    input  logic [ks01_pkg::COST_W-1:0]  i_cost,
    input  logic [ks01_pkg::VALUE_W-1:0] i_value,
    output ks01_pkg::t_row_sts    o_sts,
    output logic [COL_W-1:0]      o_wr_col,
    output logic [VAL_W-1:0]      o_best
);

    localparam int XW = (COL_W > ks01_pkg::COST_W) ? COL_W : ks01_pkg::COST_W;

    logic [VAL_W-1:0] r_mem [2**COL_W];
    logic [VAL_W-1:0] r_rd_w;
    logic [VAL_W-1:0] r_rd_wc;
    logic [COL_W-1:0] r_pw;
    logic             r_pfit;
    logic             r_pv;

    logic             fit;
    logic [COL_W-1:0] src_col;
    logic [VAL_W-1:0] cand;
    logic             take;

    always_comb begin
        fit     = XW'(i_cost) <= XW'(i_col);
        src_col = COL_W'(XW'(i_col) - XW'(i_cost));
        cand    = VAL_W'(i_value) + r_rd_wc;
        // strict improvement only
        take    = r_pv & r_pfit & (cand > r_rd_w);
    end

    always_ff @(posedge i_clk) begin
        r_rd_w  <= r_mem[i_col];
        r_rd_wc <= r_mem[src_col];
        r_pw    <= i_col;
        r_pfit  <= fit;
        if (i_ctl.clear) begin
            r_mem[i_col] <= '0;
        end else if (take) begin
            r_mem[r_pw] <= cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.issue;
        end
    end

    assign o_sts.done = r_pv;
    assign o_sts.take = take;
    assign o_wr_col   = r_pw;
    assign o_best     = r_rd_w;

endmodule

>>> src/knapsack_01_solver.sv
// 0/1 knapsack solver: item list, table fill sequencer, walk back and result queue
// add: stays idle and is ready again on the next cycle; no result
// solve, n items, clamped budget c: clears row columns 0 up to c, then fills each item's row
//   one table cell per cycle through the shared add/compare unit and its row memory
// results leave through an output register; a taken item in the walk back stalls while it is full
// reset clears the item count, the dropped flag, the sequencer and the output valid

module knapsack_01_solver #(
    parameter int MAX_ITEMS  = 32,
    parameter int MAX_BUDGET = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ks01_stream_if.sink   i_in,
    ks01_stream_if.source o_res
);

    // widths that follow from the sizes
    localparam int CW = $clog2(MAX_BUDGET + 1);
    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int NW = $clog2(MAX_ITEMS + 1);
    localparam int VW = ks01_pkg::VALUE_W + NW;
    localparam int XW = (CW > ks01_pkg::BUDGET_W) ? CW : ks01_pkg::BUDGET_W;

    // control state
    ks01_pkg::t_state r_state, n_state;
    logic [NW-1:0]    r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic             r_iss, n_iss;
    logic             r_ov, n_ov;

    // sequencer counters and result holding
    logic [CW-1:0]       r_cap, n_cap;
    logic [IW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_w, n_w;
    ks01_pkg::t_out_item r_pend, n_pend;
    ks01_pkg::t_out_item r_out, n_out;

    // item list and take table
    logic [ks01_pkg::VALUE_W-1:0] r_val_mem  [MAX_ITEMS];
    logic [ks01_pkg::COST_W-1:0]  r_cost_mem [MAX_ITEMS];
    logic                         r_tk_mem   [2**(IW+CW)];
    logic [ks01_pkg::VALUE_W-1:0] r_rd_val;
    logic [ks01_pkg::COST_W-1:0]  r_rd_cost;
    logic                         r_tk_bit;

    ks01_pkg::t_in_item  in_item;
    logic                in_acc;
    logic                out_free;
    logic                skip;
    logic [CW-1:0]       cap_sat;
    logic                add_we;
    logic                tk_we;
    logic [IW+CW-1:0]    tk_addr;
    logic                tk_din;
    ks01_pkg::t_row_ctl  row_ctl;
    ks01_pkg::t_row_sts  row_sts;
    logic [CW-1:0]       row_wr_col;
    logic [VW-1:0]       row_best;

    assign in_item     = i_in.payload;
    assign i_in.ready  = (r_state == ks01_pkg::S_IDLE);
    assign in_acc      = i_in.valid & i_in.ready;
    assign out_free    = !r_ov || o_res.ready;
    assign o_res.valid = r_ov;
    assign o_res.payload = r_out;

    // empty list or zero budget: total is zero and nothing is taken
    assign skip = (r_cnt == '0) || (r_cap == '0);

    // budget above MAX_BUDGET saturates to MAX_BUDGET
    assign cap_sat = (XW'(in_item.budget) > XW'(MAX_BUDGET)) ?
                     CW'(MAX_BUDGET) : CW'(in_item.budget);

    assign add_we = in_acc && (in_item.operation == ks01_pkg::OP_ADD) &&
                    (r_cnt < NW'(MAX_ITEMS));

    // shared add/compare unit over the best-value row
    ks01_row_unit #(
        .COL_W (CW),
        .VAL_W (VW)
    ) u_row (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (row_ctl),
        .i_col    (r_w),
        .i_cost   (r_rd_cost),
        .i_value  (r_rd_val),
        .o_sts    (row_sts),
        .o_wr_col (row_wr_col),
        .o_best   (row_best)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_iss   = r_iss;
        n_ov    = r_ov;
        n_cap   = r_cap;
        n_i     = r_i;
        n_w     = r_w;
        n_pend  = r_pend;
        n_out   = r_out;
        row_ctl = '0;
        tk_we   = 1'b0;
        tk_addr = {r_i, row_wr_col};
        tk_din  = row_sts.take;

        // output register drains when taken
        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ks01_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (in_item.operation == ks01_pkg::OP_ADD) begin
                        if (r_cnt < NW'(MAX_ITEMS)) begin
                            n_cnt = r_cnt + NW'(1);
                        end else begin
                            // list full, item is dropped
                            n_ovf = 1'b1;
                        end
                    end else begin
                        n_cap   = cap_sat;
                        n_w     = '0;
                        n_state = ks01_pkg::S_CLEAR;
                    end
                end
            end

            // zero the row, columns 0 up to the budget
            ks01_pkg::S_CLEAR: begin
                row_ctl.clear = 1'b1;
                if (r_w == r_cap) begin
                    if (skip) begin
                        n_state = ks01_pkg::S_TOTREAD;
                    end else begin
                        n_i     = '0;
                        n_state = ks01_pkg::S_LOAD;
                    end
                end else begin
                    n_w = r_w + CW'(1);
                end
            end

            // item fetch cycle; column zero is never taken
            ks01_pkg::S_LOAD: begin
                tk_we   = 1'b1;
                tk_addr = {r_i, CW'(0)};
                tk_din  = 1'b0;
                n_w     = r_cap;
                n_iss   = 1'b1;
                n_state = ks01_pkg::S_ROW;
            end

            // one cell per cycle from the budget down to column one
            ks01_pkg::S_ROW: begin
                if (r_iss) begin
                    row_ctl.issue = 1'b1;
                    if (r_w == CW'(1)) begin
                        n_iss = 1'b0;
                    end else begin
                        n_w = r_w - CW'(1);
                    end
                end
                if (row_sts.done) begin
                    tk_we = 1'b1;
                    if (row_wr_col == CW'(1)) begin
                        if ((NW'(r_i) + NW'(1)) == r_cnt) begin
                            n_w     = r_cap;
                            n_state = ks01_pkg::S_TOTREAD;
                        end else begin
                            n_i     = r_i + IW'(1);
                            n_state = ks01_pkg::S_LOAD;
                        end
                    end
                end
            end

            ks01_pkg::S_TOTREAD: begin
                n_state = ks01_pkg::S_TOTAL;
            end

            // best total becomes the first held result
            ks01_pkg::S_TOTAL: begin
                n_pend.result_kind   = ks01_pkg::KIND_TOTAL;
                n_pend.best_total    = ks01_pkg::t_total'(row_best);
                n_pend.chosen_index  = '0;
                n_pend.items_dropped = r_ovf;
                n_pend.last_result   = 1'b0;
                n_i = IW'(r_cnt - NW'(1));
                if (skip) begin
                    n_state = ks01_pkg::S_FLUSH;
                end else begin
                    n_state = ks01_pkg::S_TWAIT;
                end
            end

            ks01_pkg::S_TWAIT: begin
                n_state = ks01_pkg::S_TCHK;
            end

            // walk back: a taken item pushes the held result and is held itself
            ks01_pkg::S_TCHK: begin
                if (r_tk_bit && !out_free) begin
                    n_state = ks01_pkg::S_TCHK;
                end else begin
                    if (r_tk_bit) begin
                        n_ov  = 1'b1;
                        n_out = r_pend;
                        n_out.items_dropped = r_ovf;
                        n_out.last_result   = 1'b0;
                        n_pend.result_kind   = ks01_pkg::KIND_INDEX;
                        n_pend.best_total    = '0;
                        n_pend.chosen_index  = ks01_pkg::t_index'(r_i);
                        n_pend.items_dropped = r_ovf;
                        n_pend.last_result   = 1'b0;
                        n_w = r_w - CW'(r_rd_cost);
                    end
                    if (r_i == '0) begin
                        n_state = ks01_pkg::S_FLUSH;
                    end else begin
                        n_i     = r_i - IW'(1);
                        n_state = ks01_pkg::S_TWAIT;
                    end
                end
            end

            // held result goes out marked last; list and flag are cleared
            ks01_pkg::S_FLUSH: begin
                if (out_free) begin
                    n_ov  = 1'b1;
                    n_out = r_pend;
                    n_out.items_dropped = r_ovf;
                    n_out.last_result   = 1'b1;
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_state = ks01_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ks01_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ks01_pkg::S_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_iss   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_iss   <= n_iss;
            r_ov    <= n_ov;
        end
    end

    // counters and result payload
    always_ff @(posedge i_clk) begin
        r_cap  <= n_cap;
        r_i    <= n_i;
        r_w    <= n_w;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // item list: written on add, read at the current item
    always_ff @(posedge i_clk) begin
        if (add_we) begin
            r_val_mem[r_cnt[IW-1:0]]  <= in_item.item_value;
            r_cost_mem[r_cnt[IW-1:0]] <= in_item.item_cost;
        end
        r_rd_val  <= r_val_mem[r_i];
        r_rd_cost <= r_cost_mem[r_i];
    end

    // take table: one bit per item and column
    always_ff @(posedge i_clk) begin
        if (tk_we) begin
            r_tk_mem[tk_addr] <= tk_din;
        end
        r_tk_bit <= r_tk_mem[{r_i, r_w}];
    end

endmodule
